@@ design/skvt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skvt_pkg
// Shared constants, codes and controller/datapath structs of the sorted
// key/value table.
// ----------------------------------------------------------------------------
package skvt_pkg;

   localparam int CAPACITY_DEFAULT = 128;

   // request types
   localparam logic [2:0] OP_INSERT = 3'd0;
   localparam logic [2:0] OP_CLEAR  = 3'd1;
   localparam logic [2:0] OP_ADD    = 3'd2;
   localparam logic [2:0] OP_LOOKUP = 3'd3;
   localparam logic [2:0] OP_REMOVE = 3'd4;

   // result status codes
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_FULL     = 2'd1;
   localparam logic [1:0] ST_PRESENT  = 2'd2;
   localparam logic [1:0] ST_NOTFOUND = 2'd3;

   // read address select
   localparam logic [2:0] RD_ZERO  = 3'd0;
   localparam logic [2:0] RD_NEXT  = 3'd1;
   localparam logic [2:0] RD_PREV  = 3'd2;
   localparam logic [2:0] RD_NEXT2 = 3'd3;
   localparam logic [2:0] RD_PREV2 = 3'd4;

   typedef struct packed {
      logic       load_req;
      logic       scan_start;
      logic       scan_step;
      logic       scan_stop;
      logic       ins_init;
      logic       shift_dn;
      logic       shift_up;
      logic       write_new;
      logic       write_add;
      logic       cnt_clr;
      logic       cnt_dec;
      logic       load_rsp;
      logic [2:0] rd_sel;
      logic [1:0] rsp_status;
   } skvt_cmd_type;

   typedef struct packed {
      logic [2:0] op;
      logic       scan_stop;
      logic       scan_end;
      logic       hit;
      logic       full;
      logic       rm_need;
      logic       ins_more;
      logic       rm_more;
      logic       rsp_busy;
   } skvt_stat_type;

endpackage

@@ design/skvt_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skvt_req_if
// Request channel: valid/ready handshake with request type, key and amount.
// ----------------------------------------------------------------------------
interface skvt_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         req_type;
   logic signed [31:0] account_key;
   logic signed [31:0] amount;

   modport source (output valid, output req_type, output account_key, output amount,
                   input ready);
   modport sink   (input valid, input req_type, input account_key, input amount,
                   output ready);
endinterface

@@ design/skvt_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skvt_rsp_if
// Response channel: valid/ready handshake with the result of one request.
// ----------------------------------------------------------------------------
interface skvt_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic               found;
   logic [6:0]         entry_index;
   logic signed [31:0] entry_value;
   logic [7:0]         entry_count;

   modport source (output valid, output status, output found, output entry_index,
                   output entry_value, output entry_count, input ready);
   modport sink   (input valid, input status, input found, input entry_index,
                   input entry_value, input entry_count, output ready);
endinterface

@@ design/sorted_key_value_table_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_value_table_core
// Table of up to CAPACITY signed keys kept in ascending order, each with a
// signed Q23.8 value: insert, clear, saturating add, lookup and remove.
// ----------------------------------------------------------------------------
// One request is worked at a time. Key and value RAMs each have one read and
// one write port, and insert, add, lookup and remove walk them one entry per
// cycle up to the key or insert point. Insert then moves each entry from the
// insert point on one place higher before it writes the new entry, unless it
// appends. Remove moves each later entry one place lower, unless it removes
// the last entry. Clear and unused request types skip the walk. A new request
// is taken while the previous response still waits in its output register. No
// clearing pass is needed after reset.
module sorted_key_value_table_core #(
   parameter int CAPACITY = skvt_pkg::CAPACITY_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   skvt_req_if.sink   req_bus,
   skvt_rsp_if.source rsp_bus
);

   skvt_pkg::skvt_cmd_type  cmd;
   skvt_pkg::skvt_stat_type stat;
   logic [31:0]             rsp_value;

   skvt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   skvt_datapath #(.CAPACITY(CAPACITY)) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_type   (req_bus.req_type),
      .req_key    (req_bus.account_key),
      .req_amount (req_bus.amount),
      .rsp_ready  (rsp_bus.ready),
      .rsp_valid  (rsp_bus.valid),
      .rsp_status (rsp_bus.status),
      .rsp_found  (rsp_bus.found),
      .rsp_index  (rsp_bus.entry_index),
      .rsp_value  (rsp_value),
      .rsp_count  (rsp_bus.entry_count)
   );

   assign rsp_bus.entry_value = $signed(rsp_value);

endmodule

@@ design/skvt_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skvt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module skvt_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ design/skvt_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skvt_ctrl
// Request sequencer: scan, shift, write and response steps of one request.
// ----------------------------------------------------------------------------
module skvt_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  skvt_pkg::skvt_stat_type stat,
   output skvt_pkg::skvt_cmd_type  cmd
);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_DISPATCH = 4'd1;
   localparam logic [3:0] S_SCAN     = 4'd2;
   localparam logic [3:0] S_INS_RD   = 4'd3;
   localparam logic [3:0] S_INS_WR   = 4'd4;
   localparam logic [3:0] S_NEW_WR   = 4'd5;
   localparam logic [3:0] S_ADD_WR   = 4'd6;
   localparam logic [3:0] S_RM_RD    = 4'd7;
   localparam logic [3:0] S_RM_WR    = 4'd8;
   localparam logic [3:0] S_FINISH   = 4'd9;

   logic [3:0] state_ff, state_in;
   logic [1:0] status_ff, status_in;

   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.rsp_status = status_ff;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            status_in = skvt_pkg::ST_OK;
            case (stat.op)
               skvt_pkg::OP_INSERT, skvt_pkg::OP_ADD,
               skvt_pkg::OP_LOOKUP, skvt_pkg::OP_REMOVE: begin
                  cmd.scan_start = 1'b1;
                  cmd.rd_sel     = skvt_pkg::RD_ZERO;
                  state_in       = S_SCAN;
               end
               skvt_pkg::OP_CLEAR: begin
                  cmd.cnt_clr = 1'b1;
                  state_in    = S_FINISH;
               end
               default: begin
                  state_in = S_FINISH;
               end
            endcase
         end
         S_SCAN: begin
            cmd.rd_sel = skvt_pkg::RD_NEXT;
            if (!stat.scan_stop) begin
               cmd.scan_step = 1'b1;
            end else begin
               cmd.scan_stop = 1'b1;
               state_in      = S_FINISH;
               case (stat.op)
                  skvt_pkg::OP_INSERT: begin
                     if (stat.hit) begin
                        status_in = skvt_pkg::ST_PRESENT;
                     end else if (stat.full) begin
                        status_in = skvt_pkg::ST_FULL;
                     end else if (!stat.scan_end) begin
                        cmd.ins_init = 1'b1;
                        state_in     = S_INS_RD;
                     end else begin
                        state_in = S_NEW_WR;
                     end
                  end
                  skvt_pkg::OP_ADD: begin
                     if (stat.hit) begin
                        state_in = S_ADD_WR;
                     end else begin
                        status_in = skvt_pkg::ST_NOTFOUND;
                     end
                  end
                  skvt_pkg::OP_REMOVE: begin
                     if (!stat.hit) begin
                        status_in = skvt_pkg::ST_NOTFOUND;
                     end else if (stat.rm_need) begin
                        state_in = S_RM_RD;
                     end else begin
                        cmd.cnt_dec = 1'b1;
                     end
                  end
                  default: begin
                     if (!stat.hit) begin
                        status_in = skvt_pkg::ST_NOTFOUND;
                     end
                  end
               endcase
            end
         end
         S_INS_RD: begin
            cmd.rd_sel = skvt_pkg::RD_PREV;
            state_in   = S_INS_WR;
         end
         S_INS_WR: begin
            cmd.shift_dn = 1'b1;
            cmd.rd_sel   = skvt_pkg::RD_PREV2;
            if (!stat.ins_more) begin
               state_in = S_NEW_WR;
            end
         end
         S_NEW_WR: begin
            cmd.write_new = 1'b1;
            state_in      = S_FINISH;
         end
         S_ADD_WR: begin
            cmd.write_add = 1'b1;
            state_in      = S_FINISH;
         end
         S_RM_RD: begin
            cmd.rd_sel = skvt_pkg::RD_NEXT;
            state_in   = S_RM_WR;
         end
         S_RM_WR: begin
            cmd.shift_up = 1'b1;
            cmd.rd_sel   = skvt_pkg::RD_NEXT2;
            if (!stat.rm_more) begin
               cmd.cnt_dec = 1'b1;
               state_in    = S_FINISH;
            end
         end
         S_FINISH: begin
            if (!stat.rsp_busy) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      status_ff <= status_in;
   end

endmodule

@@ design/skvt_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skvt_datapath
// Key and value RAMs, scan and shift pointers, saturating adder, entry count
// and the response register.
// ----------------------------------------------------------------------------
module skvt_datapath #(
   parameter int CAPACITY = skvt_pkg::CAPACITY_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  skvt_pkg::skvt_cmd_type  cmd,
   output skvt_pkg::skvt_stat_type stat,
   input  logic [2:0]              req_type,
   input  logic [31:0]             req_key,
   input  logic [31:0]             req_amount,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic [1:0]              rsp_status,
   output logic                    rsp_found,
   output logic [6:0]              rsp_index,
   output logic [31:0]             rsp_value,
   output logic [7:0]              rsp_count
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > 7) ? CW : 7;
   localparam int NW = (CW > 8) ? CW : 8;

   logic [2:0]    op_ff;
   logic [31:0]   key_ff, amt_ff, val_ff;
   logic [CW-1:0] count_ff, ptr_ff, pos_ff;
   logic          found_ff, pos_ok_ff;

   logic          rsp_valid_ff, rsp_found_ff;
   logic [1:0]    rsp_status_ff;
   logic [6:0]    rsp_index_ff;
   logic [31:0]   rsp_value_ff;
   logic [7:0]    rsp_count_ff;

   logic [31:0]   rkey, rval, wkey, wval, sat_val;
   logic [CW-1:0] rd_ptr, wr_ptr;
   logic          we_key, we_val;
   logic [32:0]   sum;
   logic          scan_end, hit;
   logic [CW:0]   ptr_x, pos_x, count_x;
   logic [PW-1:0] pos_wide;
   logic [NW-1:0] count_wide;

   // saturating add of value and amount
   assign sum = {val_ff[31], val_ff} + {amt_ff[31], amt_ff};
   always_comb begin
      case (sum[32:31])
         2'b01:   sat_val = 32'h7FFF_FFFF;
         2'b10:   sat_val = 32'h8000_0000;
         default: sat_val = sum[31:0];
      endcase
   end

   always_comb begin
      case (cmd.rd_sel)
         skvt_pkg::RD_ZERO:  rd_ptr = '0;
         skvt_pkg::RD_NEXT:  rd_ptr = ptr_ff + CW'(1);
         skvt_pkg::RD_PREV:  rd_ptr = ptr_ff - CW'(1);
         skvt_pkg::RD_NEXT2: rd_ptr = ptr_ff + CW'(2);
         skvt_pkg::RD_PREV2: rd_ptr = ptr_ff - CW'(2);
         default:            rd_ptr = '0;
      endcase
   end

   always_comb begin
      wr_ptr = pos_ff;
      wkey   = key_ff;
      wval   = sat_val;
      we_key = 1'b0;
      we_val = 1'b0;
      if (cmd.shift_dn || cmd.shift_up) begin
         wr_ptr = ptr_ff;
         wkey   = rkey;
         wval   = rval;
         we_key = 1'b1;
         we_val = 1'b1;
      end else if (cmd.write_new) begin
         wval   = amt_ff;
         we_key = 1'b1;
         we_val = 1'b1;
      end else if (cmd.write_add) begin
         we_val = 1'b1;
      end
   end

   skvt_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_key_ram (
      .clock   (clock),
      .wr_en   (we_key),
      .wr_addr (wr_ptr[AW-1:0]),
      .wr_data (wkey),
      .rd_addr (rd_ptr[AW-1:0]),
      .rd_data (rkey)
   );

   skvt_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_val_ram (
      .clock   (clock),
      .wr_en   (we_val),
      .wr_addr (wr_ptr[AW-1:0]),
      .wr_data (wval),
      .rd_addr (rd_ptr[AW-1:0]),
      .rd_data (rval)
   );

   assign ptr_x    = {1'b0, ptr_ff};
   assign pos_x    = {1'b0, pos_ff};
   assign count_x  = {1'b0, count_ff};
   assign scan_end = (ptr_ff == count_ff);
   assign hit      = !scan_end && (rkey == key_ff);

   always_comb begin
      stat           = '0;
      stat.op        = op_ff;
      stat.scan_end  = scan_end;
      stat.hit       = hit;
      stat.scan_stop = scan_end || ($signed(rkey) >= $signed(key_ff));
      stat.full      = (count_ff >= CW'(CAPACITY));
      stat.rm_need   = (ptr_x + (CW+1)'(1)) < count_x;
      stat.ins_more  = ptr_x > (pos_x + (CW+1)'(1));
      stat.rm_more   = (ptr_x + (CW+1)'(2)) < count_x;
      stat.rsp_busy  = rsp_valid_ff && !rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         op_ff     <= req_type;
         key_ff    <= req_key;
         amt_ff    <= req_amount;
         found_ff  <= 1'b0;
         pos_ok_ff <= 1'b0;
         val_ff    <= '0;
      end
      if (cmd.scan_start) begin
         ptr_ff <= '0;
      end else if (cmd.ins_init) begin
         ptr_ff <= count_ff;
      end else if (cmd.scan_step || cmd.shift_up) begin
         ptr_ff <= ptr_ff + CW'(1);
      end else if (cmd.shift_dn) begin
         ptr_ff <= ptr_ff - CW'(1);
      end
      if (cmd.scan_stop) begin
         pos_ff    <= ptr_ff;
         found_ff  <= hit;
         pos_ok_ff <= hit;
         val_ff    <= hit ? rval : '0;
      end
      if (cmd.write_new) begin
         val_ff    <= amt_ff;
         pos_ok_ff <= 1'b1;
      end
      if (cmd.write_add) begin
         val_ff <= sat_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.cnt_clr) begin
         count_ff <= '0;
      end else if (cmd.write_new) begin
         count_ff <= count_ff + CW'(1);
      end else if (cmd.cnt_dec) begin
         count_ff <= count_ff - CW'(1);
      end
   end

   assign pos_wide   = PW'(pos_ff);
   assign count_wide = NW'(count_ff);

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_status_ff <= cmd.rsp_status;
         rsp_found_ff  <= found_ff;
         rsp_index_ff  <= pos_ok_ff ? pos_wide[6:0] : 7'd0;
         rsp_value_ff  <= pos_ok_ff ? val_ff : 32'd0;
         rsp_count_ff  <= count_wide[7:0];
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_found  = rsp_found_ff;
   assign rsp_index  = rsp_index_ff;
   assign rsp_value  = rsp_value_ff;
   assign rsp_count  = rsp_count_ff;

endmodule
